FILE: rtl/internal_collision_arbiter_macros.svh
// assertion macros for the internal collision arbiter checker
// expects signals clk and rst_n in the scope of use
`ifndef INTERNAL_COLLISION_ARBITER_MACROS_SVH
`define INTERNAL_COLLISION_ARBITER_MACROS_SVH

// same-cycle implication
`define ICA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication: consequent checked after the antecedent
`define ICA_ASSERT_LAT2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: rtl/ica_pkg.sv
// shared types and codes for the internal collision arbiter
// no dependencies
package ica_pkg;

  localparam logic [1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [1:0] KIND_CANCEL   = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_PENDING   = 2'd1;
  localparam logic [1:0] STATUS_NOT_AFTER = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  queue_index;
    logic [31:0] start_time;
  } ica_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        grant_valid;
    logic [1:0]  grant_queue;
    logic [3:0]  collision_mask;
    logic        next_valid;
    logic [31:0] next_time;
  } ica_out_t;

endpackage

FILE: rtl/ica_min_tree.sv
// minimum over the valid entries of a small set of times
// balanced compare tree, combinational; no package needed
module ica_min_tree #(
  parameter int N = 4,
  parameter int W = 32
) (
  input  logic [N-1:0] vld,
  input  logic [W-1:0] val [N],
  output logic         found,
  output logic [W-1:0] min_val
);

  localparam int L = (N > 1) ? $clog2(N) : 1;
  localparam int P = 1 << L;

  logic [P-1:0] v_lvl [L+1];
  logic [W-1:0] t_lvl [L+1][P];

  always_comb begin
    for (int lv = 0; lv <= L; lv++) begin
      v_lvl[lv] = '0;
      for (int i = 0; i < P; i++) begin
        t_lvl[lv][i] = '0;
      end
    end
    for (int i = 0; i < N; i++) begin
      v_lvl[0][i] = vld[i];
      t_lvl[0][i] = val[i];
    end
    for (int lv = 0; lv < L; lv++) begin
      for (int i = 0; i < P / 2; i++) begin
        if (i < (P >> (lv + 1))) begin
          v_lvl[lv+1][i] = v_lvl[lv][2*i] | v_lvl[lv][2*i+1];
          if (v_lvl[lv][2*i] &&
              (!v_lvl[lv][2*i+1] || (t_lvl[lv][2*i] <= t_lvl[lv][2*i+1]))) begin
            t_lvl[lv+1][i] = t_lvl[lv][2*i];
          end else begin
            t_lvl[lv+1][i] = t_lvl[lv][2*i+1];
          end
        end
      end
    end
  end

  assign found   = v_lvl[L][0];
  assign min_val = v_lvl[L][0] ? t_lvl[L][0] : '0;

endmodule

FILE: rtl/ica_core.sv
// queue state, time counter, arbitration and result register
// uses ica_pkg and ica_min_tree
module ica_core
  import ica_pkg::*;
#(
  parameter int NUM_QUEUES = 4,
  parameter int TIME_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  ica_in_t  item,
  output logic     out_valid,
  output ica_out_t out_item
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [NUM_QUEUES-1:0] pending_r, pending_nxt;
  logic [TIME_BITS-1:0]  cur_r, cur_nxt;
  logic [TIME_BITS-1:0]  qtime_r   [NUM_QUEUES];
  logic [TIME_BITS-1:0]  qtime_nxt [NUM_QUEUES];

  logic [NUM_QUEUES-1:0] sel, wr_en, match, gnt_oh, lost;
  logic [QW-1:0]         gnt_idx;
  logic                  gnt_found;
  logic [TIME_BITS-1:0]  req_time, tick_time;
  logic                  pend_hit, not_after;
  logic                  min_found;
  logic [TIME_BITS-1:0]  min_time;

  logic     out_valid_r, out_valid_nxt;
  ica_out_t out_item_r, out_item_nxt;

  assign req_time  = TIME_BITS'(item.start_time);
  assign tick_time = (cur_r == TIME_MAX) ? cur_r : cur_r + 1'b1;

  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      sel[q]   = (int'(item.queue_index) == q);
      match[q] = pending_r[q] && (qtime_r[q] == tick_time);
    end
    pend_hit  = |(sel & pending_r);
    not_after = (req_time <= cur_r);

    gnt_found = 1'b0;
    gnt_idx   = '0;
    gnt_oh    = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (match[q]) begin
        gnt_found = 1'b1;
        gnt_idx   = QW'(q);
        gnt_oh    = '0;
        gnt_oh[q] = 1'b1;
      end
    end
    lost = match & ~gnt_oh;

    wr_en        = '0;
    pending_nxt  = pending_r;
    cur_nxt      = cur_r;
    out_item_nxt = '0;
    if (item_vld) begin
      case (item.kind)
        KIND_SCHEDULE: begin
          if (pend_hit) begin
            out_item_nxt.status = STATUS_PENDING;
          end else if (|sel && not_after) begin
            out_item_nxt.status = STATUS_NOT_AFTER;
          end else begin
            wr_en       = sel;
            pending_nxt = pending_r | sel;
          end
        end
        KIND_CANCEL: begin
          pending_nxt = pending_r & ~sel;
        end
        KIND_TICK: begin
          cur_nxt                     = tick_time;
          pending_nxt                 = pending_r & ~match;
          out_item_nxt.grant_valid    = gnt_found;
          out_item_nxt.grant_queue    = 2'(gnt_idx);
          out_item_nxt.collision_mask = 4'(lost);
        end
        default: begin
        end
      endcase
    end

    for (int q = 0; q < NUM_QUEUES; q++) begin
      qtime_nxt[q] = wr_en[q] ? req_time : qtime_r[q];
    end
    out_item_nxt.next_valid = min_found;
    out_item_nxt.next_time  = 32'(min_time);
    out_valid_nxt           = item_vld;
  end

  ica_min_tree #(
    .N (NUM_QUEUES),
    .W (TIME_BITS)
  ) u_min (
    .vld     (pending_nxt),
    .val     (qtime_nxt),
    .found   (min_found),
    .min_val (min_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (wr_en[q]) begin
        qtime_r[q] <= req_time;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/internal_collision_arbiter.sv
// top level of the internal collision arbiter: input register and core
// uses ica_pkg and ica_core
// One transaction per clock while busy is low: busy is high in reset and until
// the first clock after reset is released, then stays low, and a transaction
// taken on start returns exactly one result, shown on out_item for one cycle
// with out_valid high. The result passes the input register and then the
// result register around the single arbitration stage (queue compare, priority
// grant, earliest-time tree). Results cannot be held off by the receiver.
module internal_collision_arbiter
  import ica_pkg::*;
#(
  parameter int NUM_QUEUES = 4,
  parameter int TIME_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ica_in_t  in_item,
  output logic     out_valid,
  output ica_out_t out_item
);

  logic    busy_r, busy_nxt;
  logic    in_vld_r, in_vld_nxt;
  ica_in_t in_item_r;

  assign busy_nxt   = 1'b0;
  assign in_vld_nxt = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_item_r <= in_item;
    end
  end

  assign busy = busy_r;

  ica_core #(
    .NUM_QUEUES (NUM_QUEUES),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item      (in_item_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/ica_checker.sv
// port-level checks for the internal collision arbiter, bound to the top level
// uses ica_pkg and internal_collision_arbiter_macros.svh
`include "internal_collision_arbiter_macros.svh"

module ica_checker
  import ica_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input ica_out_t out_item
);

  `ICA_ASSERT_LAT2(a_result_follows, start && !busy, out_valid,
                   "transaction lost its result")
  `ICA_ASSERT_IMP(a_grant_status, out_valid && out_item.grant_valid,
                  out_item.status == STATUS_OK, "grant with refusal status")
  `ICA_ASSERT_IMP(a_no_grant_clean, out_valid && !out_item.grant_valid,
                  out_item.collision_mask == 4'd0 && out_item.grant_queue == 2'd0,
                  "collision without grant")
  `ICA_ASSERT_IMP(a_next_time_zero, out_valid && !out_item.next_valid,
                  out_item.next_time == 32'd0, "next time set with nothing pending")

endmodule

bind internal_collision_arbiter ica_checker u_ica_checker (.*);
